// ===== rtl/core/bfs_pkg.sv =====
package bfs_pkg;

	// table geometry
	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// field widths
	localparam int MODE_W  = 3;
	localparam int ENTRY_W = 3;
	localparam int ELAP_W  = 16;
	localparam int ATT_W   = 8;
	localparam int CLK_W   = 32;
	localparam int FAIL_W  = 8;
	localparam int BASE_W  = 16;
	localparam int BO_W    = 28;
	localparam int CFG_W   = 28;
	localparam int CIDX_W  = 2;
	localparam int SH_W    = 4;

	// backoff shift saturates here
	localparam logic [SH_W-1:0] SHIFT_CAP = SH_W'(12);
	localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TICK    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SELECT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SUCCESS = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FAILURE = 3'd4;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_BASE_BACKOFF = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_MAX_BACKOFF  = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MAX_ATTEMPTS = 2'd2;

	// configuration reset values
	localparam logic [BASE_W-1:0] BASE_RST = 16'd30;
	localparam logic [BO_W-1:0]   MAXB_RST = 28'd1800;
	localparam logic [ATT_W-1:0]  ATT_RST  = 8'd8;

	// shared adder operations
	typedef enum logic {
		OP_ADD,
		OP_GE
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_STAMP,
		ST_FAIL_SHIFT,
		ST_FAIL_ADD,
		ST_DONE
	} state_t;

	// table write command
	typedef struct packed {
		logic [IDX_W-1:0]  addr;
		logic              set_present;
		logic              fail_we;
		logic [FAIL_W-1:0] fail_d;
		logic              nb_we;
		logic [CLK_W-1:0]  nb_d;
		logic              last_we;
		logic [CLK_W-1:0]  last_d;
	} tbl_wr_t;

	// table read data
	typedef struct packed {
		logic              present;
		logic [FAIL_W-1:0] fail;
		logic [CLK_W-1:0]  nb;
		logic [CLK_W-1:0]  last;
	} tbl_rd_t;

endpackage

// ===== rtl/core/bfs_table.sv =====
module bfs_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bfs_pkg::IDX_W-1:0] rd_addr,
	output bfs_pkg::tbl_rd_t          rd,
	input  bfs_pkg::tbl_wr_t          wr
);
	import bfs_pkg::*;

	logic              present_q [ENTRIES];
	logic [FAIL_W-1:0] fail_q    [ENTRIES];
	logic [CLK_W-1:0]  nb_q      [ENTRIES];
	logic [CLK_W-1:0]  last_q    [ENTRIES];

	// single read port
	always_comb begin
		rd.present = present_q[rd_addr];
		rd.fail    = fail_q[rd_addr];
		rd.nb      = nb_q[rd_addr];
		rd.last    = last_q[rd_addr];
	end

	// single write address, several fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				present_q[i] <= 1'b0;
				fail_q[i]    <= '0;
				nb_q[i]      <= '0;
				last_q[i]    <= '0;
			end
		end else begin
			if (wr.set_present) begin
				present_q[wr.addr] <= 1'b1;
			end
			if (wr.fail_we) begin
				fail_q[wr.addr] <= wr.fail_d;
			end
			if (wr.nb_we) begin
				nb_q[wr.addr] <= wr.nb_d;
			end
			if (wr.last_we) begin
				last_q[wr.addr] <= wr.last_d;
			end
		end
	end

endmodule

// ===== rtl/core/bfs_unit.sv =====
module bfs_unit (
	input  bfs_pkg::op_t                op,
	input  logic [bfs_pkg::CLK_W-1:0]   a,
	input  logic [bfs_pkg::CLK_W-1:0]   b,
	output logic [bfs_pkg::CLK_W-1:0]   sum,
	output logic                        ge
);
	import bfs_pkg::*;

	logic [CLK_W-1:0] b_op;
	logic             cin;
	logic [CLK_W:0]   s;

	// one adder: saturating add, or subtract for a >= b
	always_comb begin
		b_op = (op == OP_GE) ? ~b : b;
		cin  = (op == OP_GE);
		s    = {1'b0, a} + {1'b0, b_op} + (CLK_W + 1)'(cin);
		ge   = s[CLK_W];
		sum  = s[CLK_W] ? '1 : s[CLK_W-1:0];
	end

endmodule

// ===== rtl/core/backoff_failover_selector.sv =====
// channel  | handshake                  | fields
// ---------+----------------------------+------------------------------------------
// in       | in_valid / in_ready        | mode, entry, elapsed, attempts_made
// out      | out_valid / out_ready      | found, chosen, backoff_seconds
// cfg      | cfg_we (no wait)           | cfg_idx, cfg_data
//
// one item at a time through a small sequencer and one shared 33-bit adder.
// add, tick, success: exec, then done; failure: exec, fail_shift and fail_add, then done.
// select: exec, scan and stamp, then done; one table entry compared per cycle on the adder.
// the next item can be taken in the cycle after the result is loaded.
// the result sits in an output register; a new item may be taken while it waits.
// arst_n clears the table, clock and favored entry, and sets the configuration registers to their reset values.
module backoff_failover_selector (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bfs_pkg::MODE_W-1:0]  mode,
	input  logic [bfs_pkg::ENTRY_W-1:0] entry,
	input  logic [bfs_pkg::ELAP_W-1:0]  elapsed,
	input  logic [bfs_pkg::ATT_W-1:0]   attempts_made,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        found,
	output logic [bfs_pkg::ENTRY_W-1:0] chosen,
	output logic [bfs_pkg::BO_W-1:0]    backoff_seconds,
	input  logic                        cfg_we,
	input  logic [bfs_pkg::CIDX_W-1:0]  cfg_idx,
	input  logic [bfs_pkg::CFG_W-1:0]   cfg_data
);
	import bfs_pkg::*;

	state_t state_q, state_d;

	// latched item
	logic [MODE_W-1:0]  mode_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [ELAP_W-1:0]  elapsed_q;
	logic [ATT_W-1:0]   made_q;

	// scan and backoff working registers
	logic [IDX_W-1:0]   cnt_q;
	logic               have_q;
	logic [IDX_W-1:0]   best_q;
	logic [FAIL_W-1:0]  best_fail_q;
	logic [CLK_W-1:0]   best_last_q;
	logic               best_fav_q;
	logic [FAIL_W-1:0]  fail_new_q;
	logic [BO_W-1:0]    bo_q;

	// global state and configuration
	logic [CLK_W-1:0]   clock_q;
	logic [IDX_W-1:0]   favored_q;
	logic               favored_valid_q;
	logic [BASE_W-1:0]  base_q;
	logic [BO_W-1:0]    max_q;
	logic [ATT_W-1:0]   att_q;

	// output register
	logic               out_valid_q;
	logic               found_q;
	logic [ENTRY_W-1:0] chosen_q;
	logic [BO_W-1:0]    bo_out_q;

	// table and shared unit hookup
	logic [IDX_W-1:0]   rd_addr;
	tbl_rd_t            rd;
	tbl_wr_t            wr;
	op_t                u_op;
	logic [CLK_W-1:0]   u_a;
	logic [CLK_W-1:0]   u_b;
	logic [CLK_W-1:0]   u_sum;
	logic               u_ge;

	logic               accept;
	logic               entry_ok;
	logic [IDX_W-1:0]   entry_idx;
	logic [FAIL_W-1:0]  fail_inc;
	logic [SH_W-1:0]    sh_amt;
	logic [BO_W-1:0]    shifted;
	logic               fav_i;
	logic               ranks;
	logic               take;
	logic               cnt_last;
	logic               out_load;
	logic               found_d;

	bfs_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd      (rd),
		.wr      (wr)
	);

	bfs_unit u_unit (
		.op  (u_op),
		.a   (u_a),
		.b   (u_b),
		.sum (u_sum),
		.ge  (u_ge)
	);

	// item decode helpers
	assign accept    = in_valid && in_ready;
	assign entry_ok  = (32'(entry_q) < ENTRIES);
	assign entry_idx = IDX_W'(entry_q);
	assign fail_inc  = (rd.fail == FAIL_MAX) ? rd.fail : rd.fail + FAIL_W'(1);
	assign sh_amt    = (fail_new_q < FAIL_W'(SHIFT_CAP)) ? SH_W'(fail_new_q) : SHIFT_CAP;
	assign shifted   = BO_W'(base_q) << sh_amt;
	assign cnt_last  = (cnt_q == IDX_W'(ENTRIES - 1));

	// ranking of scanned entry against current best
	always_comb begin
		fav_i = favored_valid_q && (favored_q == cnt_q);
		if (fav_i != best_fav_q) begin
			ranks = fav_i;
		end else if (rd.fail != best_fail_q) begin
			ranks = rd.fail < best_fail_q;
		end else begin
			ranks = rd.last < best_last_q;
		end
		take = rd.present && u_ge && (!have_q || ranks);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (mode_q)
					MODE_SELECT: state_d = (made_q < att_q) ? ST_SCAN : ST_DONE;
					MODE_FAILURE: state_d = (entry_ok && rd.present) ? ST_FAIL_SHIFT : ST_DONE;
					default: state_d = ST_DONE;
				endcase
			end
			ST_SCAN: begin
				if (cnt_last) begin
					state_d = ST_STAMP;
				end
			end
			ST_STAMP: state_d = ST_DONE;
			ST_FAIL_SHIFT: state_d = ST_FAIL_ADD;
			ST_FAIL_ADD: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: table access and shared unit operands
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		rd_addr  = entry_idx;
		wr       = '0;
		wr.addr  = entry_idx;
		u_op     = OP_ADD;
		u_a      = clock_q;
		u_b      = '0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EXEC: begin
				case (mode_q)
					MODE_ADD: wr.set_present = entry_ok;
					MODE_TICK: u_b = CLK_W'(elapsed_q);
					MODE_SUCCESS: begin
						wr.fail_we = entry_ok && rd.present;
						wr.fail_d  = '0;
						wr.nb_we   = entry_ok && rd.present;
						wr.nb_d    = clock_q;
					end
					MODE_FAILURE: begin
						wr.fail_we = entry_ok && rd.present;
						wr.fail_d  = fail_inc;
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				rd_addr = cnt_q;
				u_op    = OP_GE;
				u_a     = clock_q;
				u_b     = rd.nb;
			end
			ST_STAMP: begin
				wr.addr    = best_q;
				wr.last_we = have_q;
				wr.last_d  = clock_q;
			end
			ST_FAIL_SHIFT: begin
				u_op = OP_GE;
				u_a  = CLK_W'(max_q);
				u_b  = CLK_W'(shifted);
			end
			ST_FAIL_ADD: begin
				u_b      = CLK_W'(bo_q);
				wr.nb_we = 1'b1;
				wr.nb_d  = u_sum;
			end
			ST_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign found_d = (mode_q == MODE_SELECT) && have_q;

	// item and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= mode;
			entry_q   <= entry;
			elapsed_q <= elapsed;
			made_q    <= attempts_made;
			have_q    <= 1'b0;
			bo_q      <= '0;
			cnt_q     <= '0;
		end
		if (state_q == ST_EXEC && mode_q == MODE_FAILURE) begin
			fail_new_q <= fail_inc;
		end
		if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + IDX_W'(1);
			if (take) begin
				have_q      <= 1'b1;
				best_q      <= cnt_q;
				best_fail_q <= rd.fail;
				best_last_q <= rd.last;
				best_fav_q  <= fav_i;
			end
		end
		if (state_q == ST_FAIL_SHIFT) begin
			bo_q <= u_ge ? shifted : max_q;
		end
		if (out_load) begin
			found_q  <= found_d;
			chosen_q <= found_d ? ENTRY_W'(best_q) : entry_q;
			bo_out_q <= bo_q;
		end
	end

	// control, clock, favored entry and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			clock_q         <= '0;
			favored_q       <= '0;
			favored_valid_q <= 1'b0;
			base_q          <= BASE_RST;
			max_q           <= MAXB_RST;
			att_q           <= ATT_RST;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EXEC && mode_q == MODE_TICK) begin
				clock_q <= u_sum;
			end
			if (state_q == ST_EXEC && mode_q == MODE_SUCCESS && entry_ok) begin
				favored_q       <= entry_idx;
				favored_valid_q <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_idx)
					CFG_BASE_BACKOFF: base_q <= cfg_data[BASE_W-1:0];
					CFG_MAX_BACKOFF: max_q <= cfg_data[BO_W-1:0];
					CFG_MAX_ATTEMPTS: att_q <= cfg_data[ATT_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign chosen          = chosen_q;
	assign backoff_seconds = bo_out_q;

endmodule
